FILE: src/tbug_pkg.sv
// package with shared types and constants of the time based uuid generator
`timescale 1ns / 1ps
`default_nettype none
package tbug_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_NODE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_ADJUST_LIMIT = 2'd1;

  // result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RETRY = 1'b1;

  // generator reload values
  localparam logic [13:0] MULT_BASE = 14'd971;
  localparam logic [16:0] ADDA_BASE = 17'd11113;
  localparam logic [17:0] ADDB_BASE = 18'd104322;
  localparam logic [31:0] SEED_BASE = 32'd4181;

  // generator step constants
  localparam logic [14:0] MULT_STEP  = 15'd7;
  localparam logic [14:0] MULT_LIMIT = 15'd9973;
  localparam logic [14:0] MULT_WRAP  = 15'd9871;
  localparam logic [17:0] ADDA_STEP  = 18'd1907;
  localparam logic [17:0] ADDA_LIMIT = 18'd99991;
  localparam logic [17:0] ADDA_WRAP  = 18'd89989;
  localparam logic [18:0] ADDB_STEP  = 19'd73939;
  localparam logic [18:0] ADDB_LIMIT = 19'd224729;
  localparam logic [18:0] ADDB_WRAP  = 19'd96233;

  localparam logic [13:0] SEQ_MASK     = 14'h3fff;
  localparam logic [1:0]  VARIANT_BITS = 2'b10;
  localparam logic [3:0]  VERSION_ONE  = 4'h1;
  localparam logic [3:0]  MAX_ADJ_RESET = 4'd9;

  typedef struct packed {
    logic [13:0] mult;
    logic [16:0] add_a;
    logic [17:0] add_b;
    logic [31:0] value;
  } rng_state_t;

  typedef struct packed {
    logic        status;
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
  } result_t;

  typedef struct packed {
    logic       initialized;
    logic [3:0] tick_adjust;
  } core_status_t;

endpackage
`default_nettype wire

FILE: src/tbug_rng.sv
// three-adder pseudo random generator step with optional reseed
`timescale 1ns / 1ps
`default_nettype none
module tbug_rng (
  input  wire logic                load,
  input  wire logic [15:0]         seed,
  input  wire tbug_pkg::rng_state_t state,
  output tbug_pkg::rng_state_t     state_next,
  output logic [15:0]              draw
);
  import tbug_pkg::*;

  rng_state_t  base;
  logic [14:0] mult_sum;
  logic [17:0] adda_sum;
  logic [18:0] addb_sum;
  logic [13:0] mult_new;
  logic [16:0] adda_new;
  logic [17:0] addb_new;
  logic [45:0] product;
  logic [31:0] value_new;

  always_comb begin
    if (load) begin
      base.mult  = MULT_BASE;
      base.add_a = ADDA_BASE;
      base.add_b = ADDB_BASE;
      base.value = SEED_BASE + {16'd0, seed};
    end else begin
      base = state;
    end

    mult_sum = {1'b0, base.mult} + MULT_STEP;
    mult_new = (mult_sum >= MULT_LIMIT) ? 14'(mult_sum - MULT_WRAP) : mult_sum[13:0];
    adda_sum = {1'b0, base.add_a} + ADDA_STEP;
    adda_new = (adda_sum >= ADDA_LIMIT) ? 17'(adda_sum - ADDA_WRAP) : adda_sum[16:0];
    addb_sum = {1'b0, base.add_b} + ADDB_STEP;
    addb_new = (addb_sum >= ADDB_LIMIT) ? 18'(addb_sum - ADDB_WRAP) : addb_sum[17:0];

    product   = base.value * mult_new;
    value_new = product[31:0] + {15'd0, adda_new} + {14'd0, addb_new};

    state_next.mult  = mult_new;
    state_next.add_a = adda_new;
    state_next.add_b = addb_new;
    state_next.value = value_new;
    draw = value_new[31:16] ^ {2'b00, value_new[13:0]};
  end

endmodule
`default_nettype wire

FILE: src/tbug_core.sv
// generator state, time compare and uuid packing for one request
`timescale 1ns / 1ps
`default_nettype none
module tbug_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   process,
  input  wire logic [63:0]            timestamp,
  input  wire logic [47:0]            node_address,
  input  wire logic [3:0]             adjust_limit,
  output tbug_pkg::result_t           result,
  output tbug_pkg::core_status_t      core_status
);
  import tbug_pkg::*;

  logic        initialized;
  logic [63:0] last_time;
  logic [3:0]  tick_adjust;
  logic [15:0] clock_sequence;
  rng_state_t  rng;

  logic        initialized_next;
  logic [63:0] last_time_next;
  logic [3:0]  tick_adjust_next;
  logic [15:0] clock_sequence_next;
  rng_state_t  rng_next;

  logic        init;
  logic [15:0] seed;
  rng_state_t  rng_step;
  logic [15:0] draw;
  logic        earlier, later, retry, bump_draw;
  logic [3:0]  eff_adj;
  logic [15:0] eff_seq, bump_src;
  logic [13:0] bumped;
  logic [63:0] adj_time;

  assign init = !initialized;
  assign seed = timestamp[15:0] ^ timestamp[31:16] ^ timestamp[47:32] ^ timestamp[63:48];

  tbug_rng u_rng (
    .load       (init),
    .seed       (seed),
    .state      (rng),
    .state_next (rng_step),
    .draw       (draw)
  );

  always_comb begin
    // first request compares as equal against its own time
    earlier = !init && (timestamp < last_time);
    later   = !init && (timestamp > last_time);
    eff_adj = init ? 4'd0 : tick_adjust;
    eff_seq = init ? draw : clock_sequence;
    retry   = !earlier && !later && (eff_adj >= adjust_limit);

    bump_draw = earlier && (clock_sequence == 16'd0);
    bump_src  = (eff_seq == 16'd0) ? draw : eff_seq;
    bumped    = (bump_src[13:0] + 14'd1) & SEQ_MASK;
    if (bumped == 14'd0) begin
      bumped = 14'd1;
    end

    // set-up of a retried first request is kept
    initialized_next    = 1'b1;
    last_time_next      = timestamp;
    tick_adjust_next    = eff_adj;
    clock_sequence_next = eff_seq;
    rng_next            = (init || bump_draw) ? rng_step : rng;
    if (!retry) begin
      if (earlier) begin
        clock_sequence_next = {2'b00, bumped};
        tick_adjust_next    = 4'd0;
      end else if (later) begin
        tick_adjust_next = 4'd0;
      end else begin
        tick_adjust_next = eff_adj + 4'd1;
      end
    end

    adj_time = timestamp + {60'd0, tick_adjust_next};
    if (retry) begin
      result.status    = STATUS_RETRY;
      result.uuid_high = 64'd0;
      result.uuid_low  = 64'd0;
    end else begin
      result.status    = STATUS_OK;
      result.uuid_high = {adj_time[31:0], adj_time[47:32], VERSION_ONE, adj_time[59:48]};
      result.uuid_low  = {VARIANT_BITS, clock_sequence_next[13:0], node_address};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initialized    <= 1'b0;
      last_time      <= 64'd0;
      tick_adjust    <= 4'd0;
      clock_sequence <= 16'd0;
      rng.mult       <= MULT_BASE;
      rng.add_a      <= ADDA_BASE;
      rng.add_b      <= ADDB_BASE;
      rng.value      <= SEED_BASE;
    end else if (process) begin
      initialized    <= initialized_next;
      last_time      <= last_time_next;
      tick_adjust    <= tick_adjust_next;
      clock_sequence <= clock_sequence_next;
      rng            <= rng_next;
    end
  end

  assign core_status.initialized = initialized;
  assign core_status.tick_adjust = tick_adjust;

endmodule
`default_nettype wire

FILE: src/time_based_uuid_generator.sv
// top level of the time based uuid generator: handshake, registers, config
// path: from the accepting edge to result valid through the input reg, then the result reg
// throughput: one transaction per cycle while out_stall is low, as the state update is combinational
//   (64-bit time compare and one 32x14 generator multiply-add in tbug_core)
// reset: synchronous, active high; clears the pipeline, the generator and
//   time state, node_address to 0 and adjust_limit to 9
`timescale 1ns / 1ps
`default_nettype none
module time_based_uuid_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] timestamp,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             status,
  output logic [63:0]      uuid_high,
  output logic [63:0]      uuid_low,
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);
  import tbug_pkg::*;

  // configuration registers
  logic [47:0] node_address;
  logic [3:0]  adjust_limit;

  // input register
  logic        s1_valid;
  logic [63:0] s1_time;

  // handshake control
  logic out_ready;   // result register free or emptied this cycle
  logic s1_ready;
  logic advance;     // s1 transaction is processed and moves to the result
  logic in_accept;

  result_t      core_result;
  core_status_t core_status;

  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign s1_ready  = !s1_valid || out_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;

  // config writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= 48'd0;
      adjust_limit <= MAX_ADJ_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_NODE_ADDRESS: node_address <= cfg_data;
        REG_ADJUST_LIMIT: adjust_limit <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_time <= timestamp;
    end
  end

  // state update happens when the transaction leaves s1
  tbug_core u_core (
    .clk          (clk),
    .rst          (rst),
    .process      (advance),
    .timestamp    (s1_time),
    .node_address (node_address),
    .adjust_limit (adjust_limit),
    .result       (core_result),
    .core_status  (core_status)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status    <= core_result.status;
      uuid_high <= core_result.uuid_high;
      uuid_low  <= core_result.uuid_low;
    end
  end

  // a retry carries no uuid
  a_retry_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_RETRY) |-> (uuid_high == 64'd0 && uuid_low == 64'd0))
    else $error("retry result carries uuid bits");

  // a good uuid has version 1 and variant bits set
  a_uuid_format: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_OK) |->
      (uuid_high[15:12] == VERSION_ONE && uuid_low[63:62] == VARIANT_BITS))
    else $error("uuid version or variant wrong");

  // set-up only happens when a transaction is processed
  a_init_on_process: assert property (@(posedge clk) disable iff (rst)
    $rose(core_status.initialized) |-> $past(advance))
    else $error("generator initialized without a transaction");

  // a processed transaction always shows up as a result next cycle
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed transaction lost");

endmodule
`default_nettype wire

FILE: test/tb_time_based_uuid_generator.sv
// testbench of the time based uuid generator: directed and random timestamp traffic
`timescale 1ns / 1ps
module tb_time_based_uuid_generator;
  import tbug_pkg::*;

  // register indexes past the end of the register list, writes there are dropped
  localparam logic [1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [1:0] REG_UNUSED_3 = 2'd3;

  // cycles the receiver holds off in the back pressure test
  localparam int HOLD_CYCLES = 300;
  // cycles to let pass once nothing is expected (two stage pipeline plus margin)
  localparam int SETTLE_CYCLES = 6;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] timestamp = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        status;
  logic [63:0] uuid_high;
  logic [63:0] uuid_low;
  logic        cfg_write_en = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [47:0] cfg_data = 48'd0;

  time_based_uuid_generator i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .timestamp    (timestamp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .uuid_high    (uuid_high),
    .uuid_low     (uuid_low),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // uuids still to come out, oldest first
  result_t expected_uuids[$];
  int mismatch_count = 0;

  // idle percentages of both sides, changed per test
  int in_idle_pct = 33;
  int out_idle_pct = 33;

  // back pressure request, the receiver counts the hold itself
  logic hold_request = 1'b0;
  int   hold_remaining = 0;

  // mirrored configuration
  logic [47:0] node_addr;
  logic [3:0]  adj_limit;

  // mirrored generator and time state
  logic        seen_first;
  logic [63:0] prev_time;
  logic [3:0]  same_tick_adj;
  logic [15:0] clk_seq;
  logic [13:0] rng_mult;
  logic [16:0] rng_a;
  logic [17:0] rng_b;
  logic [31:0] rng_val;

  task automatic clear_uuid_state();
    node_addr     = 48'd0;
    adj_limit     = MAX_ADJ_RESET;
    seen_first    = 1'b0;
    prev_time     = 64'd0;
    same_tick_adj = 4'd0;
    clk_seq       = 16'd0;
    rng_mult      = MULT_BASE;
    rng_a         = ADDA_BASE;
    rng_b         = ADDB_BASE;
    rng_val       = SEED_BASE;
  endtask

  // one step of the three adder generator, returns the 16 bit draw
  task automatic rng_draw(output logic [15:0] d);
    logic [31:0] m;
    logic [31:0] a;
    logic [31:0] b;
    m = 32'(rng_mult) + 32'(MULT_STEP);
    if (m >= 32'(MULT_LIMIT)) m = m - 32'(MULT_WRAP);
    a = 32'(rng_a) + 32'(ADDA_STEP);
    if (a >= 32'(ADDA_LIMIT)) a = a - 32'(ADDA_WRAP);
    b = 32'(rng_b) + 32'(ADDB_STEP);
    if (b >= 32'(ADDB_LIMIT)) b = b - 32'(ADDB_WRAP);
    rng_mult = m[13:0];
    rng_a    = a[16:0];
    rng_b    = b[17:0];
    rng_val  = rng_val * m + a + b;
    d = rng_val[31:16] ^ {2'b00, rng_val[13:0]};
  endtask

  // expected uuid for one accepted timestamp, updates the mirrored state
  task automatic compute_uuid(input logic [63:0] t, output result_t r);
    logic [15:0] d;
    logic [15:0] s;
    logic [63:0] at;
    logic        retry;
    retry = 1'b0;
    // set-up on the very first request, reseeds from the time words
    if (!seen_first) begin
      rng_mult = MULT_BASE;
      rng_a    = ADDA_BASE;
      rng_b    = ADDB_BASE;
      rng_val  = SEED_BASE + 32'(t[15:0] ^ t[31:16] ^ t[47:32] ^ t[63:48]);
      same_tick_adj = 4'd0;
      prev_time = t;
      rng_draw(d);
      clk_seq = d;
      seen_first = 1'b1;
    end
    if (t < prev_time) begin
      // clock went back: bump the sequence, a zero sequence is redrawn first
      s = clk_seq;
      if (s == 16'd0) rng_draw(s);
      s = {2'b00, s[13:0] + 14'd1};
      if (s == 16'd0) s = 16'd1;
      clk_seq = s;
      same_tick_adj = 4'd0;
    end else if (t > prev_time) begin
      same_tick_adj = 4'd0;
    end else if (same_tick_adj >= adj_limit) begin
      // same tick and adjustment used up: retry, nothing else changes
      retry = 1'b1;
    end else begin
      same_tick_adj = same_tick_adj + 4'd1;
    end
    if (retry) begin
      r.status    = STATUS_RETRY;
      r.uuid_high = 64'd0;
      r.uuid_low  = 64'd0;
    end else begin
      prev_time = t;
      at = t + 64'(same_tick_adj);
      r.status    = STATUS_OK;
      r.uuid_high = {at[31:0], at[47:32], VERSION_ONE, at[59:48]};
      r.uuid_low  = {VARIANT_BITS, clk_seq[13:0], node_addr};
    end
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s at %0t: got %h expected %h", field, $realtime, got, want);
    mismatch_count++;
  endtask

  // offer one timestamp transaction, with random idle cycles ahead of it;
  // valid stays high after acceptance so it is never lowered and raised in one step
  task automatic send_time(input logic [63:0] t);
    result_t want;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    timestamp <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    compute_uuid(t, want);
    expected_uuids.push_back(want);
  endtask

  // stop offering and wait until every expected uuid has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_uuids.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only called with the block idle
  task automatic write_register(input logic [1:0] idx, input logic [47:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_NODE_ADDRESS: node_addr = data;
      REG_ADJUST_LIMIT: adj_limit = data[3:0];
      default: ;
    endcase
  endtask

  // receiver side: random stall, or a long hold when asked
  always @(posedge clk) begin
    if (hold_request) begin
      hold_remaining <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_remaining != 0) begin
      hold_remaining <= hold_remaining - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_uuids.size() == 0) begin
        report_mismatch("unexpected transaction", uuid_high, 64'd0);
      end else begin
        want = expected_uuids.pop_front();
        if (status !== want.status)
          report_mismatch("status", 64'(status), 64'(want.status));
        if (uuid_high !== want.uuid_high)
          report_mismatch("uuid_high", uuid_high, want.uuid_high);
        if (uuid_low !== want.uuid_low)
          report_mismatch("uuid_low", uuid_low, want.uuid_low);
      end
    end
  end

  // first request seeds the generator and compares as equal,
  // nine same-tick uuids fit the reset limit and the tenth asks for a retry
  task automatic test_setup_and_retry();
    repeat (10) send_time(64'h0123_4567_89ab_cdef);
    drain();
  endtask

  // limit lowered below the current adjustment, then a zero limit that retries every same tick
  task automatic test_lowered_limit();
    write_register(REG_ADJUST_LIMIT, 48'd2);
    send_time(64'h0123_4567_89ab_cdef);
    drain();
    write_register(REG_ADJUST_LIMIT, 48'd0);
    send_time(64'h0123_4567_89ab_cdef);
    send_time(64'h0123_4567_89ab_cdf0);
    send_time(64'h0123_4567_89ab_cdf0);
    drain();
    write_register(REG_ADJUST_LIMIT, 48'd15);
  endtask

  // time extremes: wrap of time plus adjustment, clock going back to zero
  task automatic test_time_extremes();
    write_register(REG_NODE_ADDRESS, 48'hffff_ffff_ffff);
    send_time(64'hffff_ffff_ffff_ffff);
    send_time(64'hffff_ffff_ffff_ffff);
    send_time(64'h0000_0000_0000_0000);
    send_time(64'h0000_0000_0000_0000);
    send_time(64'h8000_0000_0000_0000);
    send_time(64'h7fff_ffff_ffff_ffff);
    drain();
  endtask

  // writes past the register list change nothing, upper data bits are dropped
  task automatic test_unused_index();
    write_register(REG_UNUSED_2, 48'hffff_ffff_ffff);
    write_register(REG_UNUSED_3, 48'h5555_aaaa_5555);
    write_register(REG_ADJUST_LIMIT, 48'hffff_ffff_fff3);
    send_time(64'h7fff_ffff_ffff_ffff);
    send_time(64'h7fff_ffff_ffff_ffff);
    drain();
  endtask

  // receiver holds off for a long time while the sender keeps offering
  task automatic test_back_pressure();
    logic [63:0] t;
    in_idle_pct  = 0;
    t = 64'h0001_0000_0000_0000;
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    repeat (40) begin
      t = t + 64'($urandom_range(0, 2));
      send_time(t);
    end
    drain();
    in_idle_pct = 33;
  endtask

  // random traffic: mostly rising time with same ticks and small steps back,
  // some wide jumps and fully random times
  task automatic test_random_traffic();
    logic [63:0] t;
    int r;
    t = {$urandom, $urandom};
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_register(REG_NODE_ADDRESS, 48'd0);
          write_register(REG_ADJUST_LIMIT, 48'd1);
        end
        1: begin
          write_register(REG_NODE_ADDRESS, 48'hffff_ffff_ffff);
          write_register(REG_ADJUST_LIMIT, 48'd15);
        end
        default: begin
          write_register(REG_NODE_ADDRESS, 48'({$urandom, $urandom}));
          write_register(REG_ADJUST_LIMIT, 48'($urandom_range(1, 15)));
        end
      endcase
      // the first phase runs with no idling on either side
      in_idle_pct  = (phase == 0) ? 0 : 33;
      out_idle_pct = (phase == 0) ? 0 : 33;
      repeat (250) begin
        r = $urandom_range(99);
        if (r < 30) begin
          // same tick
        end else if (r < 70) begin
          t = t + 64'($urandom_range(1, 500));
        end else if (r < 80) begin
          t = t + {$urandom, $urandom};
        end else if (r < 93) begin
          t = t - 64'($urandom_range(1, 500));
        end else begin
          t = {$urandom, $urandom};
        end
        send_time(t);
      end
      drain();
    end
    in_idle_pct  = 33;
    out_idle_pct = 33;
  endtask

  initial begin
    clear_uuid_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_setup_and_retry();
    test_lowered_limit();
    test_time_extremes();
    test_unused_index();
    test_back_pressure();
    test_random_traffic();
    drain();
    if (mismatch_count == 0 && expected_uuids.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: time_based_uuid_generator.f
src/tbug_pkg.sv
src/tbug_rng.sv
src/tbug_core.sv
src/time_based_uuid_generator.sv
test/tb_time_based_uuid_generator.sv
